// ===== rtl/core/iwd_pkg.sv =====
// Shared constants, codes and inter-module types for the decimating IIR filter.
// No dependencies; every other file in rtl/core refers to it by scoped name.
`default_nettype none

package iwd_pkg;

	localparam int MAX_TAPS = 8;
	localparam int TAP_W    = $clog2(MAX_TAPS);
	localparam int ADDR_W   = TAP_W + 1;
	localparam int DEPTH    = 2 * MAX_TAPS;
	localparam int CNT_W    = 4;
	localparam int RATIO_W  = 8;
	localparam int CFG_W    = 8;
	localparam int CFG_IDX_W = 2;
	localparam int OP_W     = 3;
	localparam int SAMPLE_W = 16;
	localparam int COEFF_W  = 18;
	localparam int FRAC_W   = 16;
	localparam int PROD_W   = SAMPLE_W + COEFF_W;
	localparam int ACC_W    = PROD_W + 6;
	localparam int RND_W    = ACC_W - FRAC_W;

	localparam logic signed [COEFF_W-1:0] ONE_Q16 = COEFF_W'(65536);

	// item codes
	typedef enum logic [OP_W-1:0] {
		OP_SAMPLE = 3'd0,
		OP_WR_A   = 3'd1,
		OP_WR_B   = 3'd2,
		OP_SET_X  = 3'd3,
		OP_SET_Y  = 3'd4
	} op_t;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RATIO = 2'd0,
		REG_PHASE = 2'd1,
		REG_NIN   = 2'd2,
		REG_NOUT  = 2'd3
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_FINISH
	} state_t;

	// bank bit of a memory address: feed-forward side 0, feedback side 1
	typedef struct packed {
		logic                       coef_we;
		logic [ADDR_W-1:0]          coef_waddr;
		logic signed [COEFF_W-1:0]  coef_wdata;
		logic                       hist_we;
		logic [ADDR_W-1:0]          hist_waddr;
		logic signed [SAMPLE_W-1:0] hist_wdata;
		logic                       rd_en;
		logic [ADDR_W-1:0]          coef_raddr;
		logic [ADDR_W-1:0]          hist_raddr;
		logic                       sub;
	} mem_req_t;

	typedef struct packed {
		logic                       vld;
		logic                       sub;
		logic signed [COEFF_W-1:0]  coef;
		logic signed [SAMPLE_W-1:0] hist;
	} operand_t;

	typedef struct packed {
		logic clr;
		logic commit;
	} mac_ctl_t;

	typedef struct packed {
		logic                       busy;
		logic                       out_full;
		logic signed [SAMPLE_W-1:0] res;
	} mac_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/iwd_feed_if.sv =====
// Input channel of the decimating IIR filter: samples and load items.
// Depends on iwd_pkg for field widths.
`default_nettype none

interface iwd_feed_if;
	logic                                        valid;
	logic                                        ready;
	logic [iwd_pkg::OP_W-1:0]                    op;
	logic [iwd_pkg::TAP_W-1:0]                   tap_index;
	logic signed [iwd_pkg::SAMPLE_W-1:0]         sample_value;
	logic signed [iwd_pkg::COEFF_W-1:0]          coeff_value;

	modport source (output valid, op, tap_index, sample_value, coeff_value, input ready);
	modport sink   (input valid, op, tap_index, sample_value, coeff_value, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/iwd_result_if.sv =====
// Result channel of the decimating IIR filter: one filtered sample per transfer.
// Depends on iwd_pkg for field widths.
`default_nettype none

interface iwd_result_if;
	logic                                valid;
	logic                                ready;
	logic signed [iwd_pkg::SAMPLE_W-1:0] filtered_sample;
	logic                                saturated;

	modport source (output valid, filtered_sample, saturated, input ready);
	modport sink   (input valid, filtered_sample, saturated, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/iir_filter_with_decimation_core.sv =====
// Channel     Dir  Handshake      Payload
// feed        in   valid/ready    op, tap_index, sample_value, coeff_value
// result      out  valid/ready    filtered_sample, saturated
// wr_en/...   in   write strobe   reg_index, wr_data (no read-back)
//
// Load items and samples that do not finish a decimation phase are handled as they are
// taken. A sample that finishes a phase starts a walk over the feed-forward and feedback
// taps (N and M, the clamped tap counts, 1 to 8 each): one shared multiplier walks one
// coefficient and one history entry per cycle out of the memories. Reset is asynchronous;
// memories are not cleared but per-entry valid bits give their reset contents. A held
// result stalls only the final write-back; the next item is taken once that result is registered.
`default_nettype none

module iir_filter_with_decimation_core (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          wr_en,
	input  wire logic [iwd_pkg::CFG_IDX_W-1:0] reg_index,
	input  wire logic [iwd_pkg::CFG_W-1:0]     wr_data,
	iwd_feed_if.sink                           feed,
	iwd_result_if.source                       result
);

	iwd_pkg::mem_req_t  mem_req;
	iwd_pkg::operand_t  opnd;
	iwd_pkg::mac_ctl_t  mac_ctl;
	iwd_pkg::mac_stat_t mac_stat;

	iwd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (wr_en),
		.reg_index (reg_index),
		.wr_data   (wr_data),
		.feed      (feed),
		.stat      (mac_stat),
		.req       (mem_req),
		.ctl       (mac_ctl)
	);

	iwd_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mem_req),
		.opnd   (opnd)
	);

	iwd_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.opnd   (opnd),
		.ctl    (mac_ctl),
		.stat   (mac_stat),
		.result (result)
	);

`ifndef SYNTH
	a_commit_drained: assert property (@(posedge clk) disable iff (!arst_n)
		mac_ctl.commit |-> !mac_stat.busy)
		else $error("result committed with products still in flight");

	a_ready_drained: assert property (@(posedge clk) disable iff (!arst_n)
		feed.ready |-> !mac_stat.busy)
		else $error("input ready while the accumulator pipeline is busy");

	a_result_from_commit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result.valid) |-> $past(mac_ctl.commit))
		else $error("result valid without a preceding commit");

	a_no_read_on_write: assert property (@(posedge clk) disable iff (!arst_n)
		mem_req.rd_en |-> !mem_req.hist_we && !mem_req.coef_we)
		else $error("memory write during a tap read sequence");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/iwd_store.sv =====
// Coefficient and history memories with registered reads and per-entry valid bits.
// Depends on iwd_pkg; driven by iwd_ctrl, feeds iwd_mac.
`default_nettype none

module iwd_store (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire iwd_pkg::mem_req_t req,
	output iwd_pkg::operand_t      opnd
);

	logic signed [iwd_pkg::COEFF_W-1:0]  coef_mem [iwd_pkg::DEPTH];
	logic signed [iwd_pkg::SAMPLE_W-1:0] hist_mem [iwd_pkg::DEPTH];

	logic [iwd_pkg::DEPTH-1:0] coef_vld_q;
	logic [iwd_pkg::DEPTH-1:0] hist_vld_q;

	logic signed [iwd_pkg::COEFF_W-1:0]  coef_rd_s1;
	logic signed [iwd_pkg::SAMPLE_W-1:0] hist_rd_s1;
	logic                                rd_s1;
	logic                                sub_s1;
	logic                                coef_ok_s1;
	logic                                coef_a0_s1;
	logic                                hist_ok_s1;

	always_ff @(posedge clk) begin
		if (req.coef_we) begin
			coef_mem[req.coef_waddr] <= req.coef_wdata;
		end
		if (req.hist_we) begin
			hist_mem[req.hist_waddr] <= req.hist_wdata;
		end
		if (req.rd_en) begin
			coef_rd_s1 <= coef_mem[req.coef_raddr];
			hist_rd_s1 <= hist_mem[req.hist_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_vld_q <= '0;
			hist_vld_q <= '0;
			rd_s1      <= 1'b0;
			sub_s1     <= 1'b0;
			coef_ok_s1 <= 1'b0;
			coef_a0_s1 <= 1'b0;
			hist_ok_s1 <= 1'b0;
		end else begin
			if (req.coef_we) begin
				coef_vld_q[req.coef_waddr] <= 1'b1;
			end
			if (req.hist_we) begin
				hist_vld_q[req.hist_waddr] <= 1'b1;
			end
			rd_s1      <= req.rd_en;
			sub_s1     <= req.sub;
			coef_ok_s1 <= coef_vld_q[req.coef_raddr];
			coef_a0_s1 <= (req.coef_raddr == '0);
			hist_ok_s1 <= hist_vld_q[req.hist_raddr];
		end
	end

	// never-written entries read as their reset value: a[0] is unity, all else zero
	always_comb begin
		opnd.vld = rd_s1;
		opnd.sub = sub_s1;
		if (coef_ok_s1) begin
			opnd.coef = coef_rd_s1;
		end else if (coef_a0_s1) begin
			opnd.coef = iwd_pkg::ONE_Q16;
		end else begin
			opnd.coef = '0;
		end
		opnd.hist = hist_ok_s1 ? hist_rd_s1 : '0;
	end

endmodule

`default_nettype wire

// ===== rtl/core/iwd_mac.sv =====
// Shared multiply-accumulate, rounding, saturation and the result register.
// Depends on iwd_pkg and iwd_result_if; takes operands from iwd_store.
`default_nettype none

module iwd_mac (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire iwd_pkg::operand_t  opnd,
	input  wire iwd_pkg::mac_ctl_t  ctl,
	output iwd_pkg::mac_stat_t      stat,
	iwd_result_if.source            result
);

	localparam logic signed [iwd_pkg::ACC_W-1:0] ROUND_HALF =
		iwd_pkg::ACC_W'(1 << (iwd_pkg::FRAC_W - 1));
	localparam logic signed [iwd_pkg::RND_W-1:0] SAT_MAX = iwd_pkg::RND_W'(32767);
	localparam logic signed [iwd_pkg::RND_W-1:0] SAT_MIN = -iwd_pkg::RND_W'(32768);

	logic signed [iwd_pkg::PROD_W-1:0]   prod_d;
	logic signed [iwd_pkg::PROD_W-1:0]   prod_s2;
	logic                                v_s2;
	logic                                sub_s2;
	logic signed [iwd_pkg::ACC_W-1:0]    acc_q;
	logic signed [iwd_pkg::ACC_W-1:0]    prod_ext;
	logic signed [iwd_pkg::ACC_W-1:0]    biased;
	logic signed [iwd_pkg::RND_W-1:0]    rnd;
	logic signed [iwd_pkg::SAMPLE_W-1:0] res;
	logic                                sat;
	logic                                out_vld_q;
	logic signed [iwd_pkg::SAMPLE_W-1:0] filt_q;
	logic                                sat_q;

	assign prod_d   = $signed(opnd.coef) * $signed(opnd.hist);
	assign prod_ext = iwd_pkg::ACC_W'(prod_s2);

	always_ff @(posedge clk) begin
		prod_s2 <= prod_d;
		if (ctl.commit) begin
			filt_q <= res;
			sat_q  <= sat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2      <= 1'b0;
			sub_s2    <= 1'b0;
			acc_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			v_s2   <= opnd.vld;
			sub_s2 <= opnd.sub;
			if (ctl.clr) begin
				acc_q <= '0;
			end else if (v_s2) begin
				acc_q <= sub_s2 ? (acc_q - prod_ext) : (acc_q + prod_ext);
			end
			if (ctl.commit) begin
				out_vld_q <= 1'b1;
			end else if (result.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// round half up, then floor-shift out the fraction
	always_comb begin
		biased = acc_q + ROUND_HALF;
		rnd    = biased[iwd_pkg::ACC_W-1:iwd_pkg::FRAC_W];
		sat    = 1'b1;
		if (rnd > SAT_MAX) begin
			res = SAT_MAX[iwd_pkg::SAMPLE_W-1:0];
		end else if (rnd < SAT_MIN) begin
			res = SAT_MIN[iwd_pkg::SAMPLE_W-1:0];
		end else begin
			res = rnd[iwd_pkg::SAMPLE_W-1:0];
			sat = 1'b0;
		end
	end

	assign stat.busy     = opnd.vld | v_s2;
	assign stat.out_full = out_vld_q & ~result.ready;
	assign stat.res      = res;

	assign result.valid           = out_vld_q;
	assign result.filtered_sample = filt_q;
	assign result.saturated       = sat_q;

endmodule

`default_nettype wire

// ===== rtl/core/iwd_ctrl.sv =====
// Sequencer: configuration registers, phase counter, history heads and tap walk.
// Depends on iwd_pkg and iwd_feed_if; drives iwd_store and iwd_mac.
`default_nettype none

module iwd_ctrl (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             wr_en,
	input  wire logic [iwd_pkg::CFG_IDX_W-1:0]    reg_index,
	input  wire logic [iwd_pkg::CFG_W-1:0]        wr_data,
	iwd_feed_if.sink                              feed,
	input  wire iwd_pkg::mac_stat_t               stat,
	output iwd_pkg::mem_req_t                     req,
	output iwd_pkg::mac_ctl_t                     ctl
);

	iwd_pkg::state_t state_q, state_d;

	logic [iwd_pkg::RATIO_W-1:0] ratio_q;
	logic [iwd_pkg::RATIO_W-1:0] phase_q;
	logic [iwd_pkg::RATIO_W-1:0] phase_dec;
	logic [iwd_pkg::CNT_W-1:0]   nin_q;
	logic [iwd_pkg::CNT_W-1:0]   nout_q;
	logic [iwd_pkg::CNT_W-1:0]   n_taps;
	logic [iwd_pkg::CNT_W-1:0]   m_taps;
	logic [iwd_pkg::TAP_W-1:0]   x_head_q;
	logic [iwd_pkg::TAP_W-1:0]   y_head_q;
	logic [iwd_pkg::CNT_W-1:0]   k_q;
	logic                        fb_q;

	logic                        accept;
	logic                        is_sample;
	logic                        fire;
	logic                        last_ff;
	logic                        last_fb;
	logic                        go_fb;
	logic                        issue_last;
	logic                        commit_ok;
	logic [iwd_pkg::TAP_W-1:0]   k_tap;
	logic [iwd_pkg::TAP_W-1:0]   x_rd;
	logic [iwd_pkg::TAP_W-1:0]   y_rd;
	logic [iwd_pkg::TAP_W-1:0]   x_set;
	logic [iwd_pkg::TAP_W-1:0]   y_set;
	logic [iwd_pkg::TAP_W-1:0]   x_new;
	logic [iwd_pkg::TAP_W-1:0]   y_new;

	function automatic logic [iwd_pkg::CNT_W-1:0] clamp_taps(
		input logic [iwd_pkg::CNT_W-1:0] n
	);
		logic [iwd_pkg::CNT_W-1:0] r;
		r = n;
		if (n == '0) begin
			r = iwd_pkg::CNT_W'(1);
		end else if (n > iwd_pkg::CNT_W'(iwd_pkg::MAX_TAPS)) begin
			r = iwd_pkg::CNT_W'(iwd_pkg::MAX_TAPS);
		end
		return r;
	endfunction

	assign n_taps    = clamp_taps(nin_q);
	assign m_taps    = clamp_taps(nout_q);
	assign accept    = feed.valid & feed.ready;
	assign is_sample = (feed.op == iwd_pkg::OP_SAMPLE);
	assign phase_dec = phase_q - iwd_pkg::RATIO_W'(1);
	assign fire      = accept & is_sample & (phase_dec == '0);

	assign last_ff    = (k_q == n_taps - iwd_pkg::CNT_W'(1));
	assign last_fb    = (k_q == m_taps - iwd_pkg::CNT_W'(1));
	assign go_fb      = (m_taps != iwd_pkg::CNT_W'(1));
	assign issue_last = fb_q ? last_fb : (last_ff & ~go_fb);
	assign commit_ok  = ~stat.busy & ~stat.out_full;

	// history entry i lives at head + i; newest sample sits at the head
	assign k_tap = k_q[iwd_pkg::TAP_W-1:0];
	assign x_rd  = x_head_q + k_tap;
	assign y_rd  = y_head_q + k_tap - iwd_pkg::TAP_W'(1);
	assign x_set = x_head_q + feed.tap_index;
	assign y_set = y_head_q + feed.tap_index;
	assign x_new = x_head_q - iwd_pkg::TAP_W'(1);
	assign y_new = y_head_q - iwd_pkg::TAP_W'(1);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			iwd_pkg::ST_IDLE: begin
				if (fire) begin
					state_d = iwd_pkg::ST_ISSUE;
				end
			end
			iwd_pkg::ST_ISSUE: begin
				if (issue_last) begin
					state_d = iwd_pkg::ST_FINISH;
				end
			end
			iwd_pkg::ST_FINISH: begin
				if (commit_ok) begin
					state_d = iwd_pkg::ST_IDLE;
				end
			end
			default: state_d = iwd_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		feed.ready = 1'b0;
		req        = '0;
		ctl        = '0;
		unique case (state_q)
			iwd_pkg::ST_IDLE: begin
				feed.ready = 1'b1;
				ctl.clr    = fire;
				if (accept) begin
					unique case (feed.op)
						iwd_pkg::OP_SAMPLE: begin
							req.hist_we    = fire;
							req.hist_waddr = {1'b0, x_new};
							req.hist_wdata = feed.sample_value;
						end
						iwd_pkg::OP_WR_A: begin
							req.coef_we    = 1'b1;
							req.coef_waddr = {1'b0, feed.tap_index};
							req.coef_wdata = feed.coeff_value;
						end
						iwd_pkg::OP_WR_B: begin
							// feedback tap zero always holds zero
							req.coef_we    = 1'b1;
							req.coef_waddr = {1'b1, feed.tap_index};
							req.coef_wdata = (feed.tap_index == '0) ? '0 : feed.coeff_value;
						end
						iwd_pkg::OP_SET_X: begin
							req.hist_we    = 1'b1;
							req.hist_waddr = {1'b0, x_set};
							req.hist_wdata = feed.sample_value;
						end
						iwd_pkg::OP_SET_Y: begin
							req.hist_we    = 1'b1;
							req.hist_waddr = {1'b1, y_set};
							req.hist_wdata = feed.sample_value;
						end
						default: begin
							req.hist_we = 1'b0;
						end
					endcase
				end
			end
			iwd_pkg::ST_ISSUE: begin
				req.rd_en      = 1'b1;
				req.sub        = fb_q;
				req.coef_raddr = {fb_q, k_tap};
				req.hist_raddr = fb_q ? {1'b1, y_rd} : {1'b0, x_rd};
			end
			iwd_pkg::ST_FINISH: begin
				ctl.commit     = commit_ok;
				req.hist_we    = commit_ok;
				req.hist_waddr = {1'b1, y_new};
				req.hist_wdata = stat.res;
			end
			default: begin
				feed.ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= iwd_pkg::ST_IDLE;
			ratio_q  <= iwd_pkg::RATIO_W'(1);
			phase_q  <= iwd_pkg::RATIO_W'(1);
			nin_q    <= iwd_pkg::CNT_W'(1);
			nout_q   <= iwd_pkg::CNT_W'(1);
			x_head_q <= '0;
			y_head_q <= '0;
			k_q      <= '0;
			fb_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (wr_en) begin
				unique case (reg_index)
					iwd_pkg::REG_RATIO: ratio_q <= wr_data;
					iwd_pkg::REG_PHASE: phase_q <= wr_data;
					iwd_pkg::REG_NIN:   nin_q   <= wr_data[iwd_pkg::CNT_W-1:0];
					iwd_pkg::REG_NOUT:  nout_q  <= wr_data[iwd_pkg::CNT_W-1:0];
					default:            ratio_q <= ratio_q;
				endcase
			end else if (accept && is_sample) begin
				// reload from the ratio when the count runs out
				phase_q <= (phase_dec == '0) ? ratio_q : phase_dec;
			end
			if (fire) begin
				x_head_q <= x_new;
				k_q      <= '0;
				fb_q     <= 1'b0;
			end else if (state_q == iwd_pkg::ST_ISSUE) begin
				if (!fb_q && last_ff && go_fb) begin
					fb_q <= 1'b1;
					k_q  <= iwd_pkg::CNT_W'(1);
				end else begin
					k_q <= k_q + iwd_pkg::CNT_W'(1);
				end
			end
			if (ctl.commit) begin
				y_head_q <= y_new;
			end
		end
	end

endmodule

`default_nettype wire

// ===== test/tb_iir_filter_with_decimation_core.sv =====
// Self-checking bench for iir_filter_with_decimation_core: a directed table, then random
// phases over several decimation and tap settings, with an item-level filter predictor.
// Depends on iwd_pkg, iwd_feed_if, iwd_result_if and the core itself.

module tb_iir_filter_with_decimation_core;
	import iwd_pkg::*;

	localparam int LIMIT_CYCLES = 400000;
	localparam int HOLD_CYCLES  = 300;
	// give the block some margin after its longest compute before a register write
	localparam int IDLE_TAIL    = 24;
	localparam int MAX_REPORTS  = 10;

	// codes the block must ignore
	localparam logic [OP_W-1:0] OP_BAD_FIRST = 3'd5;
	localparam logic [OP_W-1:0] OP_BAD_LAST  = 3'd7;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       sat;
	} filt_out_t;

	typedef struct packed {
		logic [OP_W-1:0]            op;
		logic [TAP_W-1:0]           idx;
		logic signed [SAMPLE_W-1:0] sv;
		logic signed [COEFF_W-1:0]  cv;
		logic                       fixed;
		logic signed [SAMPLE_W-1:0] exp_sample;
		logic                       exp_sat;
	} feed_row_t;

	typedef struct packed {
		logic [CFG_W-1:0] ratio;
		logic [CFG_W-1:0] phase;
		logic [CFG_W-1:0] nin;
		logic [CFG_W-1:0] nout;
		logic [15:0]      count;
		logic [7:0]       sample_pct;
	} run_phase_t;

	// reset state: ratio 1, one tap each side, a[0] = 1.0, so samples pass through
	localparam feed_row_t DIR_ROWS [25] = '{
		'{OP_SAMPLE,    3'd0, 16'sh0000, 18'sh00000, 1'b1, 16'sh0000, 1'b0},
		'{OP_SAMPLE,    3'd0, 16'sh7fff, 18'sh00000, 1'b1, 16'sh7fff, 1'b0},
		'{OP_SAMPLE,    3'd0, 16'sh8000, 18'sh00000, 1'b1, 16'sh8000, 1'b0},
		'{OP_BAD_FIRST, 3'd7, 16'sh1234, 18'sh3ffff, 1'b0, 16'sh0000, 1'b0},
		'{OP_BAD_LAST,  3'd0, 16'sh7fff, 18'sh1ffff, 1'b0, 16'sh0000, 1'b0},
		'{OP_WR_A,      3'd0, 16'sh0000, 18'sh1ffff, 1'b0, 16'sh0000, 1'b0},
		'{OP_SAMPLE,    3'd0, 16'sh7fff, 18'sh00000, 1'b1, 16'sh7fff, 1'b1},
		'{OP_SAMPLE,    3'd0, 16'sh8000, 18'sh00000, 1'b1, 16'sh8000, 1'b1},
		'{OP_WR_A,      3'd0, 16'sh0000, 18'sh20000, 1'b0, 16'sh0000, 1'b0},
		'{OP_SAMPLE,    3'd0, 16'sh8000, 18'sh00000, 1'b1, 16'sh7fff, 1'b1},
		'{OP_SAMPLE,    3'd0, 16'sh0001, 18'sh00000, 1'b1, -16'sd2,   1'b0},
		// a[0] = 0.5: halves round toward plus infinity
		'{OP_WR_A,      3'd0, 16'sh0000, 18'sh08000, 1'b0, 16'sh0000, 1'b0},
		'{OP_SAMPLE,    3'd0, 16'sh0001, 18'sh00000, 1'b1, 16'sh0001, 1'b0},
		'{OP_SAMPLE,    3'd0, -16'sd1,   18'sh00000, 1'b1, 16'sh0000, 1'b0},
		'{OP_SAMPLE,    3'd0, 16'sh0003, 18'sh00000, 1'b1, 16'sh0002, 1'b0},
		'{OP_WR_A,      3'd0, 16'sh0000, 18'sh10000, 1'b0, 16'sh0000, 1'b0},
		// feedback tap zero must store zero
		'{OP_WR_B,      3'd0, 16'sh0000, 18'sh1ffff, 1'b0, 16'sh0000, 1'b0},
		'{OP_WR_B,      3'd7, 16'sh0000, 18'sh20000, 1'b0, 16'sh0000, 1'b0},
		'{OP_WR_A,      3'd7, 16'sh0000, 18'sh1ffff, 1'b0, 16'sh0000, 1'b0},
		'{OP_SET_X,     3'd7, 16'sh8000, 18'sh00000, 1'b0, 16'sh0000, 1'b0},
		'{OP_SET_X,     3'd0, 16'sh7fff, 18'sh00000, 1'b0, 16'sh0000, 1'b0},
		'{OP_SET_Y,     3'd7, 16'sh7fff, 18'sh00000, 1'b0, 16'sh0000, 1'b0},
		'{OP_SET_Y,     3'd0, 16'sh8000, 18'sh00000, 1'b0, 16'sh0000, 1'b0},
		'{OP_SAMPLE,    3'd7, 16'sh7fff, 18'sh20000, 1'b1, 16'sh7fff, 1'b0},
		'{OP_WR_B,      3'd1, 16'sh0000, 18'sh10000, 1'b0, 16'sh0000, 1'b0}
	};

	// tap counts 0 and above MAX_TAPS, ratio and phase 0 (256 samples) and 255
	localparam run_phase_t RUN_PHASES [5] = '{
		'{8'd1,   8'd1,   8'd8,  8'd8,  16'd50,  8'd75},
		'{8'd3,   8'd2,   8'd0,  8'd15, 16'd50,  8'd75},
		'{8'd255, 8'd0,   8'd5,  8'd3,  16'd280, 8'd97},
		'{8'd0,   8'd255, 8'd15, 8'd0,  16'd280, 8'd97},
		'{8'd2,   8'd1,   8'd4,  8'd6,  16'd50,  8'd75}
	};

	logic                 clk;
	logic                 arst_n;
	logic                 wr_en;
	logic [CFG_IDX_W-1:0] reg_index;
	logic [CFG_W-1:0]     wr_data;

	iwd_feed_if   feed ();
	iwd_result_if result ();

	iir_filter_with_decimation_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (wr_en),
		.reg_index (reg_index),
		.wr_data   (wr_data),
		.feed      (feed),
		.result    (result)
	);

	// predictor state
	logic signed [SAMPLE_W-1:0] hist_x  [MAX_TAPS];
	logic signed [SAMPLE_W-1:0] hist_y  [MAX_TAPS];
	logic signed [COEFF_W-1:0]  coef_ff [MAX_TAPS];
	logic signed [COEFF_W-1:0]  coef_fb [MAX_TAPS];
	logic [RATIO_W-1:0]         ratio_reg;
	logic [RATIO_W-1:0]         phase_cnt;
	logic [CNT_W-1:0]           nin_reg;
	logic [CNT_W-1:0]           nout_reg;

	filt_out_t                  pending_outputs [$];
	logic                       table_check;
	logic signed [SAMPLE_W-1:0] table_sample;
	logic                       table_sat;

	int   err_cnt;
	int   cycle_cnt;
	logic hold_rx;
	logic tx_eager;
	logic rx_eager;

	always #1 clk = ~clk;

	function automatic int draw_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic int tap_span(input logic [CNT_W-1:0] v);
		if (v == 0)
			return 1;
		if (v > MAX_TAPS)
			return MAX_TAPS;
		return v;
	endfunction

	task automatic reset_filter_state();
		for (int k = 0; k < MAX_TAPS; k++) begin
			hist_x[k]  = '0;
			hist_y[k]  = '0;
			coef_ff[k] = '0;
			coef_fb[k] = '0;
		end
		coef_ff[0] = ONE_Q16;
		ratio_reg  = 8'd1;
		phase_cnt  = 8'd1;
		nin_reg    = 4'd1;
		nout_reg   = 4'd1;
	endtask

	// Apply one item to the predictor; returns 1 when it yields a filtered sample.
	function automatic logic filter_item(
		input  logic [OP_W-1:0]            op,
		input  logic [TAP_W-1:0]           idx,
		input  logic signed [SAMPLE_W-1:0] sv,
		input  logic signed [COEFF_W-1:0]  cv,
		output filt_out_t                  res
	);
		longint acc;
		longint rounded;
		int     n_ff;
		int     n_fb;
		res = '0;
		if (op != OP_SAMPLE) begin
			case (op)
				OP_WR_A:  coef_ff[idx] = cv;
				OP_WR_B:  coef_fb[idx] = (idx == 0) ? '0 : cv;
				OP_SET_X: hist_x[idx]  = sv;
				OP_SET_Y: hist_y[idx]  = sv;
				default: ;
			endcase
			return 1'b0;
		end
		phase_cnt = phase_cnt - 8'd1;
		if (phase_cnt != 0)
			return 1'b0;
		phase_cnt = ratio_reg;
		for (int k = MAX_TAPS - 1; k > 0; k--)
			hist_x[k] = hist_x[k-1];
		hist_x[0] = sv;
		n_ff = tap_span(nin_reg);
		n_fb = tap_span(nout_reg);
		acc = 0;
		for (int k = 0; k < n_ff; k++)
			acc += longint'(coef_ff[k]) * longint'(hist_x[k]);
		for (int k = 1; k < n_fb; k++)
			acc -= longint'(coef_fb[k]) * longint'(hist_y[k-1]);
		rounded = (acc + 64'sd32768) >>> FRAC_W;
		if (rounded > 32767) begin
			rounded = 32767;
			res.sat = 1'b1;
		end else if (rounded < -32768) begin
			rounded = -32768;
			res.sat = 1'b1;
		end
		res.sample = SAMPLE_W'(rounded);
		for (int k = MAX_TAPS - 1; k > 0; k--)
			hist_y[k] = hist_y[k-1];
		hist_y[0] = res.sample;
		return 1'b1;
	endfunction

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] value);
		@(negedge clk);
		wr_en     = 1'b1;
		reg_index = idx;
		wr_data   = value;
		case (idx)
			REG_RATIO: ratio_reg = value;
			REG_PHASE: phase_cnt = value;
			REG_NIN:   nin_reg   = value[CNT_W-1:0];
			REG_NOUT:  nout_reg  = value[CNT_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		wr_en = 1'b0;
	endtask

	task automatic send_item(
		input logic [OP_W-1:0]            op,
		input logic [TAP_W-1:0]           idx,
		input logic signed [SAMPLE_W-1:0] sv,
		input logic signed [COEFF_W-1:0]  cv,
		input logic                       fixed,
		input logic signed [SAMPLE_W-1:0] exp_sample,
		input logic                       exp_sat
	);
		int gap;
		gap = tx_eager ? 0 : draw_gap();
		@(negedge clk);
		if (gap > 0) begin
			feed.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		feed.valid        = 1'b1;
		feed.op           = op;
		feed.tap_index    = idx;
		feed.sample_value = sv;
		feed.coeff_value  = cv;
		table_check       = fixed;
		table_sample      = exp_sample;
		table_sat         = exp_sat;
		do
			@(posedge clk);
		while (!feed.ready);
	endtask

	task automatic random_item(input int sample_pct);
		int                         r;
		logic [OP_W-1:0]            op;
		logic signed [SAMPLE_W-1:0] sv;
		logic signed [COEFF_W-1:0]  cv;
		r  = $urandom_range(0, 99);
		sv = SAMPLE_W'($urandom);
		if ($urandom_range(0, 9) == 0) begin
			case ($urandom_range(0, 2))
				0:       sv = 16'sh7fff;
				1:       sv = 16'sh8000;
				default: sv = '0;
			endcase
		end
		// mostly modest coefficients so the feedback loop does not sit in saturation
		if ($urandom_range(0, 3) == 0)
			cv = COEFF_W'($urandom);
		else
			cv = COEFF_W'(int'($urandom_range(0, 24576)) - 12288);
		if (r < sample_pct)
			op = OP_SAMPLE;
		else if (r < 98)
			op = OP_W'($urandom_range(OP_WR_A, OP_SET_Y));
		else
			op = OP_W'($urandom_range(OP_BAD_FIRST, OP_BAD_LAST));
		send_item(op, TAP_W'($urandom), sv, cv, 1'b0, '0, 1'b0);
	endtask

	// Hold the feed until every expected output has arrived, then let the core settle.
	task automatic drain();
		@(negedge clk);
		feed.valid = 1'b0;
		while (pending_outputs.size() != 0)
			@(posedge clk);
		repeat (IDLE_TAIL) @(posedge clk);
	endtask

	// predict on each feed transfer, check each result transfer
	always @(posedge clk) begin
		filt_out_t want;
		filt_out_t got;
		logic      made;
		if (arst_n && feed.valid && feed.ready) begin
			made = filter_item(feed.op, feed.tap_index, feed.sample_value, feed.coeff_value,
				want);
			if (table_check) begin
				want.sample = table_sample;
				want.sat    = table_sat;
			end
			if (made || table_check)
				pending_outputs.push_back(want);
		end
		if (arst_n && result.valid && result.ready) begin
			got.sample = result.filtered_sample;
			got.sat    = result.saturated;
			if (pending_outputs.size() == 0) begin
				err_cnt++;
				if (err_cnt <= MAX_REPORTS)
					$display("unexpected output: sample %0d sat %0b", got.sample, got.sat);
			end else begin
				want = pending_outputs.pop_front();
				if (got.sample !== want.sample || got.sat !== want.sat) begin
					err_cnt++;
					if (err_cnt <= MAX_REPORTS)
						$display("output mismatch: expected %0d sat %0b, got %0d sat %0b",
							want.sample, want.sat, got.sample, got.sat);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= LIMIT_CYCLES) begin
			$display("tb_iir_filter_with_decimation_core: done, errors");
			$finish;
		end
	end

	// result side: random stalls, eager stretches and one long hold-off on request
	initial begin
		int stall_left;
		int g;
		stall_left   = 0;
		result.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_rx) begin
				result.ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_rx = 1'b0;
			end
			if (rx_eager) begin
				result.ready = 1'b1;
			end else if (stall_left > 0) begin
				result.ready = 1'b0;
				stall_left--;
			end else begin
				g            = draw_gap();
				result.ready = (g == 0);
				stall_left   = (g > 0) ? g - 1 : 0;
			end
		end
	end

	initial begin
		run_phase_t ph;
		clk               = 1'b0;
		arst_n            = 1'b0;
		wr_en             = 1'b0;
		reg_index         = REG_RATIO;
		wr_data           = '0;
		feed.valid        = 1'b0;
		feed.op           = OP_SAMPLE;
		feed.tap_index    = '0;
		feed.sample_value = '0;
		feed.coeff_value  = '0;
		table_check       = 1'b0;
		table_sample      = '0;
		table_sat         = 1'b0;
		err_cnt           = 0;
		cycle_cnt         = 0;
		hold_rx           = 1'b0;
		tx_eager          = 1'b0;
		rx_eager          = 1'b0;
		reset_filter_state();

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (DIR_ROWS[i])
			send_item(DIR_ROWS[i].op, DIR_ROWS[i].idx, DIR_ROWS[i].sv, DIR_ROWS[i].cv,
				DIR_ROWS[i].fixed, DIR_ROWS[i].exp_sample, DIR_ROWS[i].exp_sat);
		drain();

		foreach (RUN_PHASES[p]) begin
			ph = RUN_PHASES[p];
			write_reg(REG_RATIO, ph.ratio);
			write_reg(REG_NIN, ph.nin);
			write_reg(REG_NOUT, ph.nout);
			write_reg(REG_PHASE, ph.phase);
			tx_eager = (p == 1);
			rx_eager = (p == 1);
			for (int i = 0; i < ph.count; i++) begin
				// fill the core against a stalled output
				if (p == 0 && i == ph.count / 3)
					hold_rx = 1'b1;
				// pause the feed until every output is back
				if (p == 4 && i == ph.count / 2)
					drain();
				random_item(ph.sample_pct);
			end
			drain();
		end

		if (err_cnt == 0)
			$display("tb_iir_filter_with_decimation_core: done, clean");
		else
			$display("tb_iir_filter_with_decimation_core: done, errors");
		$finish;
	end

endmodule
